// ===== design/rphbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rphbm_pkg: shared types and constants of the peak-hold bar meter
// Level thresholds in 0.01 dBm, input and class codes, and the scaling
// constants used to map a level onto the bar.
// ----------------------------------------------------------------------------
package rphbm_pkg;

	localparam int LEVEL_W = 18;
	localparam int PROD_W  = 22;   // clamped level times segments, plus rounding half

	typedef logic signed [LEVEL_W-1:0] level_t;

	localparam level_t PENDING_LEVEL = -18'sd99900;
	localparam level_t PENDING_LIMIT = -18'sd99800;
	localparam level_t SCALE_MIN     = -18'sd16000;
	localparam level_t CLASS_STRONG  = -18'sd7000;
	localparam level_t CLASS_CLEAR   = -18'sd9000;
	localparam level_t CLASS_WEAK    = -18'sd11000;

	localparam logic [13:0] SCALE_SPAN = 14'd16000;
	localparam logic [12:0] SCALE_HALF = 13'd8000;

	// Division by 16000 is a shift by 7 and then a division by 125, the latter
	// done as a multiply by ceil(2^22 / 125) and a shift by 22 (exact below 59074).
	localparam int             DIV_PRE_SHIFT = 7;
	localparam int             DIV_SHIFT     = 22;
	localparam logic [15:0]    DIV_RECIP     = 16'd33555;

	localparam logic [7:0]  BAR_SEGMENTS_RST = 8'd64;
	localparam logic [15:0] HOLD_TICKS_RST   = 16'd5000;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_e;

	typedef enum logic {
		REG_BAR_SEGMENTS = 1'b0,
		REG_HOLD_TICKS   = 1'b1
	} reg_index_e;

	typedef enum logic [2:0] {
		CLS_PENDING = 3'd0,
		CLS_NOISE   = 3'd1,
		CLS_WEAK    = 3'd2,
		CLS_CLEAR   = 3'd3,
		CLS_STRONG  = 3'd4
	} level_class_e;

	// Contents of the first pipeline stage for one sample.
	typedef struct packed {
		logic              pending;
		logic              peak_set;
		level_class_e      cls;
		level_t            peak;
		logic [PROD_W-1:0] fill_prod;
		logic [PROD_W-1:0] peak_prod;
	} stage1_t;

endpackage
`default_nettype wire

// ===== design/rphbm_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rphbm_scale: rounded bar product of one level
// Clamps a level to -160..0 dBm, offsets it to 0..16000 and multiplies by the
// segment count, adding half a step so a later division by 16000 rounds.
// ----------------------------------------------------------------------------
module rphbm_scale (
	input  wire rphbm_pkg::level_t               level,
	input  wire logic [7:0]                      segments,
	output logic [rphbm_pkg::PROD_W-1:0]         prod
);
	import rphbm_pkg::*;

	level_t      offset;
	logic [13:0] pos;

	always_comb begin
		offset = level - SCALE_MIN;
		if (level < SCALE_MIN) begin
			pos = 14'd0;
		end else if (level > 18'sd0) begin
			pos = SCALE_SPAN;
		end else begin
			pos = offset[13:0];
		end
		prod = PROD_W'(pos) * PROD_W'(segments) + PROD_W'(SCALE_HALF);
	end

endmodule
`default_nettype wire

// ===== design/rssi_peak_hold_bar_meter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_peak_hold_bar_meter_core: peak-hold signal meter with bar graph output
// One band's level meter: holds a peak with a hold timer and renders each
// sample as a bar fill, a peak marker and a level class.
// ----------------------------------------------------------------------------
// Input words are either samples (op = 0, level in 0.01 dBm) or time ticks
// (op = 1). A tick only advances the hold timer and yields no output word.
// A sample first updates the held peak, which takes the sample when the peak
// is unset, when the sample exceeds it, or when the timer has reached
// hold_ticks; the timer then restarts. Each sample yields one output word with
// the bar fill, the marker position (drawn only at or above the fill), the
// level class and the held peak. Levels at or below -998 dBm are pending.
// The block takes one word per clock cycle unless stalled. A sample's result
// goes through two register stages once accepted: the first holds the rounded
// bar products of the sample and of the peak, the second the quotients by
// 16000, worked out by a constant reciprocal multiply. When the output is
// stalled, the two stages fill and in_ready drops after that. Configuration
// (bar_segments at index 0, hold_ticks at index 1) must be written while the
// block is idle.
// ----------------------------------------------------------------------------
module rssi_peak_hold_bar_meter_core (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	// configuration write port
	input  wire  logic                cfg_we,
	input  wire  logic                cfg_index,
	input  wire  logic [15:0]         cfg_data,
	// input words
	input  wire  logic                in_valid,
	output logic                      in_ready,
	input  wire  logic                op,
	input  wire  rphbm_pkg::level_t   sample_level,
	// output words
	output logic                      out_valid,
	input  wire  logic                out_ready,
	output logic [7:0]                fill_count,
	output logic                      marker_shown,
	output logic [7:0]                marker_index,
	output logic [2:0]                level_class,
	output rphbm_pkg::level_t         peak_level,
	output logic                      peak_valid
);
	import rphbm_pkg::*;

	// Configuration registers.
	logic [7:0]  bar_segments_q;
	logic [15:0] hold_ticks_q;

	// Meter state.
	level_t      held_peak_q;
	logic [15:0] ticks_q;

	// Pipeline.
	logic        valid_s1;
	stage1_t     data_s1;
	logic        out_valid_q;
	logic [7:0]  fill_s2;
	logic        shown_s2;
	logic [7:0]  index_s2;
	logic [2:0]  class_s2;
	level_t      peak_s2;
	logic        peak_valid_s2;

	logic        out_adv;
	logic        in_acc;
	logic        sample_acc;
	logic        take_peak;
	level_t      new_peak;
	stage1_t     data_n;

	logic [PROD_W-1:0] fill_prod;
	logic [PROD_W-1:0] peak_prod;

	logic [30:0] fill_mul;
	logic [30:0] peak_mul;
	logic [7:0]  fill_q;
	logic [7:0]  peak_q;
	logic [7:0]  fill_n;
	logic [7:0]  index_raw;
	logic        shown_n;
	logic [7:0]  index_n;

	// ---------------------------------------------------------------- handshake
	// The output register moves when it is empty or being taken; stage one
	// moves when it is empty or the output register moves.
	assign out_adv    = !out_valid_q || out_ready;
	assign in_ready   = !valid_s1 || out_adv;
	assign in_acc     = in_valid && in_ready;
	assign sample_acc = in_acc && (op == OP_SAMPLE);

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_segments_q <= BAR_SEGMENTS_RST;
			hold_ticks_q   <= HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (reg_index_e'(cfg_index))
				REG_BAR_SEGMENTS: bar_segments_q <= cfg_data[7:0];
				REG_HOLD_TICKS:   hold_ticks_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// ---------------------------------------------------------------- peak hold
	// The peak is replaced when it is unset, beaten, or its hold has expired.
	always_comb begin
		take_peak = (held_peak_q <= PENDING_LIMIT) || (sample_level > held_peak_q) ||
			(ticks_q >= hold_ticks_q);
		new_peak  = take_peak ? sample_level : held_peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_peak_q <= PENDING_LEVEL;
			ticks_q     <= 16'd0;
		end else if (in_acc) begin
			if (op == OP_TICK) begin
				if (ticks_q != 16'hFFFF) begin
					ticks_q <= ticks_q + 16'd1;
				end
			end else if (take_peak) begin
				held_peak_q <= sample_level;
				ticks_q     <= 16'd0;
			end
		end
	end

	// ---------------------------------------------------------------- stage one
	rphbm_scale u_fill_scale (
		.level    (sample_level),
		.segments (bar_segments_q),
		.prod     (fill_prod)
	);

	rphbm_scale u_peak_scale (
		.level    (new_peak),
		.segments (bar_segments_q),
		.prod     (peak_prod)
	);

	always_comb begin
		data_n.pending   = (sample_level <= PENDING_LIMIT);
		data_n.peak_set  = (new_peak > PENDING_LIMIT);
		data_n.peak      = new_peak;
		data_n.fill_prod = fill_prod;
		data_n.peak_prod = peak_prod;
		if (sample_level <= PENDING_LIMIT) begin
			data_n.cls = CLS_PENDING;
		end else if (sample_level >= CLASS_STRONG) begin
			data_n.cls = CLS_STRONG;
		end else if (sample_level >= CLASS_CLEAR) begin
			data_n.cls = CLS_CLEAR;
		end else if (sample_level >= CLASS_WEAK) begin
			data_n.cls = CLS_WEAK;
		end else begin
			data_n.cls = CLS_NOISE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= sample_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			data_s1 <= data_n;
		end
	end

	// ---------------------------------------------------------------- stage two
	// Quotient by 16000: drop seven bits, then multiply by the reciprocal of 125.
	always_comb begin
		fill_mul = 31'(data_s1.fill_prod[PROD_W-1:DIV_PRE_SHIFT]) * 31'(DIV_RECIP);
		peak_mul = 31'(data_s1.peak_prod[PROD_W-1:DIV_PRE_SHIFT]) * 31'(DIV_RECIP);
		fill_q   = fill_mul[DIV_SHIFT+7:DIV_SHIFT];
		peak_q   = peak_mul[DIV_SHIFT+7:DIV_SHIFT];

		if (data_s1.pending) begin
			fill_n = 8'd0;
		end else if (fill_q > bar_segments_q) begin
			fill_n = bar_segments_q;
		end else begin
			fill_n = fill_q;
		end

		// A peak at full scale sits on the last segment.
		index_raw = (peak_q >= bar_segments_q) ? (bar_segments_q - 8'd1) : peak_q;
		shown_n   = data_s1.peak_set && !data_s1.pending && (bar_segments_q != 8'd0) &&
			(index_raw >= fill_n);
		index_n   = shown_n ? index_raw : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			fill_s2       <= fill_n;
			shown_s2      <= shown_n;
			index_s2      <= index_n;
			class_s2      <= data_s1.cls;
			peak_s2       <= data_s1.peak;
			peak_valid_s2 <= data_s1.peak_set;
		end
	end

	assign out_valid    = out_valid_q;
	assign fill_count   = fill_s2;
	assign marker_shown = shown_s2;
	assign marker_index = index_s2;
	assign level_class  = class_s2;
	assign peak_level   = peak_s2;
	assign peak_valid   = peak_valid_s2;

	// ---------------------------------------------------------------- assertions
	a_peak_valid_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (peak_valid_s2 == (peak_s2 > PENDING_LIMIT)))
		else $error("peak_valid disagrees with the delivered peak level");

	a_marker_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && shown_s2) |-> ((index_s2 >= fill_s2) && (index_s2 < bar_segments_q)))
		else $error("shown marker lies below the fill or beyond the bar");

	a_marker_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !shown_s2) |-> (index_s2 == 8'd0))
		else $error("hidden marker carries a nonzero index");

	a_pending_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (class_s2 == CLS_PENDING)) |-> ((fill_s2 == 8'd0) && !shown_s2))
		else $error("pending sample drew a bar or a marker");

	a_peak_beaten: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && (sample_level > held_peak_q)) |=>
			((held_peak_q == $past(sample_level)) && (ticks_q == 16'd0)))
		else $error("higher sample did not replace the held peak");

endmodule
`default_nettype wire
